/* rtl/vertex_project_to_window_assert.svh */
// ----------------------------------------------------------------------------
// vertex_project_to_window assertion macros
// clocked assertion shorthands, sampled on clk and disabled during rst
// ----------------------------------------------------------------------------
`ifndef VERTEX_PROJECT_TO_WINDOW_ASSERT_SVH
`define VERTEX_PROJECT_TO_WINDOW_ASSERT_SVH

// property holds at every edge out of reset
`define VPW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition at one edge implies a consequence at the next
`define VPW_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

/* rtl/vpw_pkg.sv */
// ----------------------------------------------------------------------------
// vpw_pkg
// shared types and constants for the vertex projection block
// ----------------------------------------------------------------------------
`default_nettype none

package vpw_pkg;

  localparam int COORD_WIDTH   = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int INDEX_W       = 5;
  localparam int STORE_DEPTH   = 32;
  localparam int QUEUE_DEPTH   = 2;   // power of two
  localparam int ORIGIN_W      = 16;
  localparam int VIEW_W        = 15;
  localparam int CFG_DATA_W    = 16;
  localparam int CFG_INDEX_W   = 2;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_PROJECT = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_X = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_Y = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_WIDTH    = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_HEIGHT   = 2'd3;

  localparam logic [VIEW_W-1:0] RESET_WIDTH  = 15'd640;
  localparam logic [VIEW_W-1:0] RESET_HEIGHT = 15'd480;

  typedef struct packed {
    logic                          load;
    logic [INDEX_W-1:0]            index;
    logic signed [COORD_WIDTH-1:0] value;
    logic signed [COORD_WIDTH-1:0] x;
    logic signed [COORD_WIDTH-1:0] y;
    logic signed [COORD_WIDTH-1:0] z;
  } item_t;

  typedef struct packed {
    logic signed [ORIGIN_W-1:0] origin_x;
    logic signed [ORIGIN_W-1:0] origin_y;
    logic [VIEW_W-1:0]          width;
    logic [VIEW_W-1:0]          height;
  } view_t;

endpackage

`default_nettype wire

/* rtl/vpw_front.sv */
// ----------------------------------------------------------------------------
// vpw_front
// accepts requests, tags them as load or project, queues them for the back end
// ----------------------------------------------------------------------------
`default_nettype none

module vpw_front (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  push,
  output logic                                  full,
  input  logic                                  cmd,
  input  logic [vpw_pkg::INDEX_W-1:0]           entry_index,
  input  logic signed [vpw_pkg::COORD_WIDTH-1:0] entry_value,
  input  logic signed [vpw_pkg::COORD_WIDTH-1:0] point_x,
  input  logic signed [vpw_pkg::COORD_WIDTH-1:0] point_y,
  input  logic signed [vpw_pkg::COORD_WIDTH-1:0] point_z,
  output vpw_pkg::item_t                        item,
  output logic                                  avail,
  input  logic                                  take
);

  localparam int PTR_W = $clog2(vpw_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(vpw_pkg::QUEUE_DEPTH + 1);

  vpw_pkg::item_t   slots [vpw_pkg::QUEUE_DEPTH];
  vpw_pkg::item_t   incoming;
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             accept;
  logic             take_ok;

  always_comb begin
    incoming.load  = (cmd == vpw_pkg::CMD_LOAD);
    incoming.index = entry_index;
    incoming.value = entry_value;
    incoming.x     = point_x;
    incoming.y     = point_y;
    incoming.z     = point_z;
  end

  assign full    = (count == CNT_W'(vpw_pkg::QUEUE_DEPTH));
  assign avail   = (count != '0);
  assign accept  = push && !full;
  assign take_ok = take && avail;
  assign item    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (accept) begin
      slots[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (accept) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (take_ok) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({accept, take_ok})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/vpw_div.sv */
// ----------------------------------------------------------------------------
// vpw_div
// signed divider, one quotient bit per cycle, truncates toward zero
// ----------------------------------------------------------------------------
`default_nettype none

module vpw_div #(
  parameter int NUM_W = 48,
  parameter int DEN_W = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic signed [NUM_W-1:0] numer,
  input  logic signed [DEN_W-1:0] denom,
  output logic                   done,
  output logic signed [NUM_W:0]   quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [NUM_W-1:0] q;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_mag;
  logic             neg;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   diff;

  // remainder stays below the divisor, so the shifted value fits DEN_W+1 bits
  assign rem_sh = {rem, q[NUM_W-1]};
  assign diff   = rem_sh - {1'b0, den_mag};
  assign quot   = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy    <= 1'b1;
        cnt     <= CNT_W'(NUM_W);
        q       <= numer[NUM_W-1] ? NUM_W'(-numer) : NUM_W'(numer);
        den_mag <= denom[DEN_W-1] ? DEN_W'(-denom) : DEN_W'(denom);
        rem     <= '0;
        neg     <= numer[NUM_W-1] ^ denom[DEN_W-1];
      end else if (busy) begin
        q   <= {q[NUM_W-2:0], !diff[DEN_W]};
        rem <= diff[DEN_W] ? rem_sh[DEN_W-1:0] : diff[DEN_W-1:0];
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/vpw_back.sv */
// ----------------------------------------------------------------------------
// vpw_back
// matrix store, transform sequencer, divides and viewport mapping
// ----------------------------------------------------------------------------
`default_nettype none

module vpw_back #(
  parameter int FRAC_BITS = vpw_pkg::FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  vpw_pkg::view_t                         view,
  input  vpw_pkg::item_t                         item,
  input  logic                                   avail,
  output logic                                   take,
  input  logic                                   res_pop,
  output logic                                   busy,
  output logic                                   res_valid,
  output logic signed [vpw_pkg::COORD_WIDTH-1:0] window_x,
  output logic signed [vpw_pkg::COORD_WIDTH-1:0] window_y,
  output logic signed [vpw_pkg::COORD_WIDTH-1:0] window_depth,
  output logic                                   ok
);

  localparam int CW     = vpw_pkg::COORD_WIDTH;
  localparam int VW     = vpw_pkg::VIEW_W;
  localparam int OW     = vpw_pkg::ORIGIN_W;
  localparam int AW     = vpw_pkg::INDEX_W;
  localparam int PROD_W = 2 * CW;
  localparam int TERM_W = PROD_W - FRAC_BITS;
  localparam int ACC_W  = TERM_W + 2;
  localparam int NUM_W  = CW + FRAC_BITS;
  localparam int NDC_W  = NUM_W + 1;
  localparam int SUM1_W = NDC_W + 1;
  localparam int WP_W   = SUM1_W + VW + 1;
  localparam int WIN_W  = WP_W + 1;
  localparam int SAT_W  = (WIN_W > ACC_W) ? WIN_W : ACC_W;

  localparam logic signed [CW-1:0] ONE = {{(CW-1){1'b0}}, 1'b1} << FRAC_BITS;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_RD     = 4'd1;
  localparam logic [3:0] S_MUL    = 4'd2;
  localparam logic [3:0] S_ACC    = 4'd3;
  localparam logic [3:0] S_SWAP   = 4'd4;
  localparam logic [3:0] S_CHECK  = 4'd5;
  localparam logic [3:0] S_DSTART = 4'd6;
  localparam logic [3:0] S_DWAIT  = 4'd7;
  localparam logic [3:0] S_WX     = 4'd8;
  localparam logic [3:0] S_WXA    = 4'd9;
  localparam logic [3:0] S_WY     = 4'd10;
  localparam logic [3:0] S_WYA    = 4'd11;
  localparam logic [3:0] S_OUT    = 4'd12;

  function automatic logic signed [CW-1:0] sat_c(input logic signed [SAT_W-1:0] v);
    logic signed [SAT_W-1:0] hi;
    logic signed [SAT_W-1:0] lo;
    begin
      hi = SAT_W'({1'b0, {(CW-1){1'b1}}});
      lo = ~hi;
      if (v > hi) begin
        sat_c = hi[CW-1:0];
      end else if (v < lo) begin
        sat_c = lo[CW-1:0];
      end else begin
        sat_c = v[CW-1:0];
      end
    end
  endfunction

  logic [3:0]                state;
  logic [1:0]                row;
  logic [1:0]                col;
  logic [1:0]                k;
  logic                      mat_sel;
  logic signed [CW-1:0]      vin  [4];
  logic signed [CW-1:0]      vout [4];
  logic signed [ACC_W-1:0]   acc;
  logic signed [ACC_W-1:0]   acc_sum;
  logic signed [PROD_W-1:0]  prod;
  logic signed [TERM_W-1:0]  term;
  logic signed [NDC_W-1:0]   ndc [3];
  logic signed [WP_W-1:0]    wprod;
  logic signed [CW-1:0]      res_x;
  logic signed [CW-1:0]      res_y;
  logic signed [CW-1:0]      res_d;
  logic                      res_ok;
  logic [CW-1:0]             store_mem [vpw_pkg::STORE_DEPTH];
  logic [vpw_pkg::STORE_DEPTH-1:0] store_valid;
  logic signed [CW-1:0]      rd_data;
  logic                      rd_ok;
  logic [AW-1:0]             rd_addr;
  logic                      div_start;
  logic                      div_done;
  logic signed [NUM_W-1:0]   div_num;
  logic signed [NDC_W-1:0]   div_quot;
  logic signed [SUM1_W-1:0]  win_a;
  logic signed [VW:0]        win_b;
  logic signed [OW-1:0]      win_org;
  logic signed [SAT_W-1:0]   win_sum;
  logic signed [SUM1_W-1:0]  depth_a;
  logic signed [SAT_W-1:0]   depth_sum;
  logic                      slot_free;

  // entry address is matrix, column, row
  assign rd_addr   = {mat_sel, col, row};
  assign take      = (state == S_IDLE) && avail;
  assign busy      = (state != S_IDLE);
  assign slot_free = !res_valid || res_pop;

  // floor to the fraction bits, then accumulate exactly
  assign term    = $signed(prod[PROD_W-1:FRAC_BITS]);
  assign acc_sum = acc + ACC_W'(term);

  assign div_start = (state == S_DSTART);
  assign div_num   = {vout[k], {FRAC_BITS{1'b0}}};

  assign win_a     = SUM1_W'((state == S_WX) ? ndc[0] : ndc[1]) + SUM1_W'(ONE);
  assign win_b     = $signed({1'b0, (state == S_WX) ? view.width : view.height});
  assign win_org   = (state == S_WXA) ? view.origin_x : view.origin_y;
  assign win_sum   = (SAT_W'(win_org) <<< FRAC_BITS) + SAT_W'(wprod >>> 1);
  assign depth_a   = SUM1_W'(ndc[2]) + SUM1_W'(ONE);
  assign depth_sum = SAT_W'(depth_a) >>> 1;

  vpw_div #(
    .NUM_W (NUM_W),
    .DEN_W (CW)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .numer (div_num),
    .denom (vout[3]),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    if (take && item.load) begin
      store_mem[item.index] <= item.value;
    end
    rd_data <= store_mem[rd_addr];
    rd_ok   <= store_valid[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      res_valid   <= 1'b0;
      store_valid <= '0;
    end else begin
      // the final step refills the slot itself
      if (res_valid && res_pop && (state != S_OUT)) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (avail) begin
            if (item.load) begin
              store_valid[item.index] <= 1'b1;
            end else begin
              vin[0]  <= item.x;
              vin[1]  <= item.y;
              vin[2]  <= item.z;
              vin[3]  <= ONE;
              mat_sel <= 1'b0;
              row     <= '0;
              col     <= '0;
              acc     <= '0;
              state   <= S_RD;
            end
          end
        end
        S_RD: begin
          state <= S_MUL;
        end
        S_MUL: begin
          prod  <= $signed(rd_ok ? rd_data : '0) * vin[col];
          state <= S_ACC;
        end
        S_ACC: begin
          if (col == 2'd3) begin
            vout[row] <= sat_c(SAT_W'(acc_sum));
            acc       <= '0;
            col       <= '0;
            if (row == 2'd3) begin
              row   <= '0;
              state <= S_SWAP;
            end else begin
              row   <= row + 1'b1;
              state <= S_RD;
            end
          end else begin
            acc   <= acc_sum;
            col   <= col + 1'b1;
            state <= S_RD;
          end
        end
        S_SWAP: begin
          if (!mat_sel) begin
            vin     <= vout;
            mat_sel <= 1'b1;
            state   <= S_RD;
          end else begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (vout[3] == '0) begin
            res_x  <= '0;
            res_y  <= '0;
            res_d  <= '0;
            res_ok <= 1'b0;
            state  <= S_OUT;
          end else begin
            k     <= '0;
            state <= S_DSTART;
          end
        end
        S_DSTART: begin
          state <= S_DWAIT;
        end
        S_DWAIT: begin
          if (div_done) begin
            ndc[k] <= div_quot;
            if (k == 2'd2) begin
              state <= S_WX;
            end else begin
              k     <= k + 1'b1;
              state <= S_DSTART;
            end
          end
        end
        S_WX: begin
          wprod <= win_a * win_b;
          state <= S_WXA;
        end
        S_WXA: begin
          res_x <= sat_c(win_sum);
          state <= S_WY;
        end
        S_WY: begin
          wprod <= win_a * win_b;
          state <= S_WYA;
        end
        S_WYA: begin
          res_y  <= sat_c(win_sum);
          res_d  <= sat_c(depth_sum);
          res_ok <= 1'b1;
          state  <= S_OUT;
        end
        S_OUT: begin
          if (slot_free) begin
            res_valid    <= 1'b1;
            window_x     <= res_x;
            window_y     <= res_y;
            window_depth <= res_d;
            ok           <= res_ok;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/vertex_project_to_window.sv */
// ----------------------------------------------------------------------------
// vertex_project_to_window
// projects object-space points to window coordinates in signed fixed point
// ----------------------------------------------------------------------------
// Requests enter through a push/full queue: cmd 0 loads one matrix entry
// (0-15 model, 16-31 projection, column-major), cmd 1 projects a point with
// w = 1 through both matrices, divides by clip w and maps x and y into the
// viewport and z from -1..1 onto 0..1; each projection gives one result on
// the empty/pop side, loads give none. The 32 multiply-accumulate terms of
// a projection go one at a time through the read, multiply and accumulate
// states, a single multiplier and the one-port matrix store, and the three
// divisions go one quotient bit per cycle through one shared divider. A
// zero clip w skips the divides and returns ok = 0 with zero coordinates.
// A two-deep request queue in front and a result register behind let both
// sides stall on their own. The matrix store clears to zero at reset
// through per-entry valid bits, so no clearing pass is needed.
// Viewport registers are written through cfg_valid/cfg_ready; the user
// must write them only while idle, the block itself does not enforce it.
`default_nettype none
`include "vertex_project_to_window_assert.svh"

module vertex_project_to_window #(
  parameter int FRAC_BITS = vpw_pkg::FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // request side
  input  logic                                   push,
  output logic                                   full,
  input  logic                                   cmd,
  input  logic [vpw_pkg::INDEX_W-1:0]            entry_index,
  input  logic signed [vpw_pkg::COORD_WIDTH-1:0] entry_value,
  input  logic signed [vpw_pkg::COORD_WIDTH-1:0] point_x,
  input  logic signed [vpw_pkg::COORD_WIDTH-1:0] point_y,
  input  logic signed [vpw_pkg::COORD_WIDTH-1:0] point_z,
  // result side
  output logic                                   empty,
  input  logic                                   pop,
  output logic signed [vpw_pkg::COORD_WIDTH-1:0] window_x,
  output logic signed [vpw_pkg::COORD_WIDTH-1:0] window_y,
  output logic signed [vpw_pkg::COORD_WIDTH-1:0] window_depth,
  output logic                                   ok,
  // viewport register writes
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [vpw_pkg::CFG_INDEX_W-1:0]        cfg_index,
  input  logic [vpw_pkg::CFG_DATA_W-1:0]         cfg_data
);

  vpw_pkg::view_t view;
  vpw_pkg::item_t fe_item;
  logic           fe_avail;
  logic           bk_take;
  logic           bk_busy;
  logic           res_valid;
  logic           res_pop;

  // register writes are always accepted
  assign cfg_ready = 1'b1;
  assign empty     = !res_valid;
  assign res_pop   = pop && res_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      view.origin_x <= '0;
      view.origin_y <= '0;
      view.width    <= vpw_pkg::RESET_WIDTH;
      view.height   <= vpw_pkg::RESET_HEIGHT;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        vpw_pkg::REG_ORIGIN_X: view.origin_x <= $signed(cfg_data);
        vpw_pkg::REG_ORIGIN_Y: view.origin_y <= $signed(cfg_data);
        vpw_pkg::REG_WIDTH:    view.width    <= cfg_data[vpw_pkg::VIEW_W-1:0];
        vpw_pkg::REG_HEIGHT:   view.height   <= cfg_data[vpw_pkg::VIEW_W-1:0];
        default:               view          <= view;
      endcase
    end
  end

  // front end: request queue with load/project tag
  vpw_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .cmd         (cmd),
    .entry_index (entry_index),
    .entry_value (entry_value),
    .point_x     (point_x),
    .point_y     (point_y),
    .point_z     (point_z),
    .item        (fe_item),
    .avail       (fe_avail),
    .take        (bk_take)
  );

  // back end: store, transform, divide, map, result register
  vpw_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .view         (view),
    .item         (fe_item),
    .avail        (fe_avail),
    .take         (bk_take),
    .res_pop      (res_pop),
    .busy         (bk_busy),
    .res_valid    (res_valid),
    .window_x     (window_x),
    .window_y     (window_y),
    .window_depth (window_depth),
    .ok           (ok)
  );

  // a failed projection carries zero coordinates
  `VPW_ASSERT(a_fail_zero, (!empty && !ok) |-> (window_x == '0 && window_y == '0 && window_depth == '0), "failed projection with non-zero coordinates")
  // a result only appears out of the back end's final step
  `VPW_ASSERT(a_result_from_work, $rose(!empty) |-> $past(bk_busy), "result appeared with no projection in work")
  // a full queue always offers a request to the back end
  `VPW_ASSERT(a_full_offers, full |-> fe_avail, "request queue full but nothing offered")
  // an idle back end cannot refill a popped result
  `VPW_ASSERT_NEXT(a_pop_idle, pop && !empty && !bk_busy, empty, "result refilled while idle")

endmodule

`default_nettype wire
